[hw/rtl/wmcr_pkg.sv]
// ----------------------------------------------------------------------------
// wmcr_pkg
// Shared types, constants and helpers for the min/max waveform column renderer.
// ----------------------------------------------------------------------------
package wmcr_pkg;

    // Limits and field widths
    localparam int MAX_COLUMNS = 64;
    localparam int MAX_ROWS    = 256;
    localparam int SAMPLE_W    = 8;
    localparam int COUNT_W     = 16;
    localparam int COLS_W      = 7;
    localparam int ROWS_W      = 9;
    localparam int COL_W       = 6;
    localparam int ROW_W       = 8;
    localparam int DIV_STEPS   = COUNT_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 2'd2;

    // Channel payloads
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_value;
    } t_sample;

    typedef struct packed {
        logic [COL_W-1:0] column;
        logic [ROW_W-1:0] top_row;
        logic [ROW_W-1:0] bottom_row;
        logic [ROW_W-1:0] center_row;
        logic             last_column;
    } t_column;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_INIT,
        ST_MINMAX,
        ST_MUL,
        ST_ROW,
        ST_LAST
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load;       // latch accepted sample
        logic div_start;  // load divider with sample count
        logic div_step;   // one restoring-divide step
        logic init_cols;  // set up column 0 bounds
        logic minmax;     // fold sample into running min/max
        logic mul;        // register row products
        logic row;        // close column, emit pending, advance
        logic emit_last;  // emit final column
        logic finish;     // sample done, bump sample index
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic active;     // render in progress and registers usable
        logic init;       // column stepping already set up
        logic cont;       // sample does not close current column
        logic brk;        // next column starts after this sample
        logic is_last;    // current column is the final one
        logic pend_valid; // a column waits for its stretch
        logic out_free;   // output register can take a beat
    } t_sts;

    // Exact floor(p / 255) for 16-bit p up to 255 * 255
    function automatic logic [ROW_W-1:0] div255(input logic [15:0] p);
        logic [16:0] t;
        begin
            t = {1'b0, p} + {9'd0, p[15:8]} + 17'd1;
            div255 = t[15:8];
        end
    endfunction

endpackage

[hw/rtl/wmcr_stream_if.sv]
// ----------------------------------------------------------------------------
// wmcr_stream_if
// Valid/ready channel carrying one payload beat of type T.
// ----------------------------------------------------------------------------
interface wmcr_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[hw/rtl/wmcr_ctrl.sv]
// ----------------------------------------------------------------------------
// wmcr_ctrl
// Sequencer for one sample: divider setup, min/max fold, column close-out.
// ----------------------------------------------------------------------------
module wmcr_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  wmcr_pkg::t_sts i_sts,
    output wmcr_pkg::t_cmd o_cmd
);

    wmcr_pkg::t_state                    r_state, n_state;
    logic [wmcr_pkg::DIV_CNT_W-1:0]      r_cnt, n_cnt;
    logic                                accept;
    logic                                row_go;

    assign o_in_ready = (r_state == wmcr_pkg::ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    // pending column needs the output register before the row step runs
    assign row_go     = !i_sts.pend_valid || i_sts.out_free;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wmcr_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            wmcr_pkg::ST_IDLE: begin
                n_cnt = '0;
                if (accept && i_sts.active) begin
                    n_state = i_sts.init ? wmcr_pkg::ST_MINMAX : wmcr_pkg::ST_DIV;
                end
            end
            wmcr_pkg::ST_DIV: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == wmcr_pkg::DIV_CNT_W'(wmcr_pkg::DIV_STEPS - 1)) begin
                    n_state = wmcr_pkg::ST_INIT;
                end
            end
            wmcr_pkg::ST_INIT: begin
                n_state = wmcr_pkg::ST_MINMAX;
            end
            wmcr_pkg::ST_MINMAX: begin
                n_state = i_sts.cont ? wmcr_pkg::ST_IDLE : wmcr_pkg::ST_MUL;
            end
            wmcr_pkg::ST_MUL: begin
                n_state = wmcr_pkg::ST_ROW;
            end
            wmcr_pkg::ST_ROW: begin
                if (row_go) begin
                    if (i_sts.is_last) begin
                        n_state = wmcr_pkg::ST_LAST;
                    end else if (i_sts.brk) begin
                        n_state = wmcr_pkg::ST_IDLE;
                    end else begin
                        n_state = wmcr_pkg::ST_MINMAX;
                    end
                end
            end
            wmcr_pkg::ST_LAST: begin
                if (i_sts.out_free) begin
                    n_state = wmcr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = wmcr_pkg::ST_IDLE;
            end
        endcase
    end

    // Command outputs
    always_comb begin
        o_cmd = '0;
        case (r_state)
            wmcr_pkg::ST_IDLE: begin
                o_cmd.load      = accept;
                o_cmd.div_start = accept && i_sts.active && !i_sts.init;
            end
            wmcr_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            wmcr_pkg::ST_INIT: begin
                o_cmd.init_cols = 1'b1;
            end
            wmcr_pkg::ST_MINMAX: begin
                o_cmd.minmax = 1'b1;
                o_cmd.finish = i_sts.cont;
            end
            wmcr_pkg::ST_MUL: begin
                o_cmd.mul = 1'b1;
            end
            wmcr_pkg::ST_ROW: begin
                o_cmd.row    = row_go;
                o_cmd.finish = row_go && !i_sts.is_last && i_sts.brk;
            end
            wmcr_pkg::ST_LAST: begin
                o_cmd.emit_last = i_sts.out_free;
                o_cmd.finish    = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

[hw/rtl/wmcr_datapath.sv]
// ----------------------------------------------------------------------------
// wmcr_datapath
// Config registers, column bound stepping, min/max, row scaling, output beat.
// ----------------------------------------------------------------------------
module wmcr_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wmcr_pkg::t_cmd    i_cmd,
    output wmcr_pkg::t_sts    o_sts,
    input  logic              i_cfg_we,
    input  wmcr_pkg::t_cfg    i_cfg,
    input  wmcr_pkg::t_sample i_sample,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output wmcr_pkg::t_column o_out
);

    localparam int CW = wmcr_pkg::COLS_W;
    localparam int NW = wmcr_pkg::COUNT_W;
    localparam int RW = wmcr_pkg::ROW_W;
    localparam int VW = wmcr_pkg::SAMPLE_W;

    // Config registers
    logic [NW-1:0]                 r_n;
    logic [CW-1:0]                 r_w;
    logic [wmcr_pkg::ROWS_W-1:0]   r_h;
    logic                          cfg_hit;

    // Render state
    logic [CW-1:0] r_col;
    logic [NW-1:0] r_samp;
    logic          r_init;
    logic [VW-1:0] r_v;
    logic [VW-1:0] r_min, r_max;
    logic [RW-1:0] r_ptop, r_pbot;
    logic          r_pv;
    logic [NW-1:0] r_q;      // raw end of current column
    logic [CW-1:0] r_acc;    // running remainder of (x+1)*n mod w
    logic [NW-1:0] r_cend;   // end of current column, exclusive
    logic [NW-1:0] r_quo;    // divider quotient, then n / w
    logic [CW-1:0] r_drem;   // divider remainder, then n % w
    logic [15:0]   r_prod_t, r_prod_b;
    logic          r_ovalid;
    wmcr_pkg::t_column r_out;

    // Effective geometry
    logic [CW-1:0]               w_eff;
    logic [wmcr_pkg::ROWS_W-1:0] h_eff;
    logic [RW-1:0]               h_m1;
    logic [RW-1:0]               center;

    always_comb begin
        if (r_w > CW'(wmcr_pkg::MAX_COLUMNS)) w_eff = CW'(wmcr_pkg::MAX_COLUMNS);
        else                                   w_eff = r_w;
        if (r_h == '0)                                         h_eff = 9'd1;
        else if (r_h > wmcr_pkg::ROWS_W'(wmcr_pkg::MAX_ROWS))  h_eff =
            wmcr_pkg::ROWS_W'(wmcr_pkg::MAX_ROWS);
        else                                                   h_eff = r_h;
    end
    assign h_m1   = RW'(h_eff - 9'd1);
    assign center = h_eff[8:1];

    // Config write decode
    always_comb begin
        case (i_cfg.index)
            wmcr_pkg::REG_SAMPLE_COUNT: cfg_hit = i_cfg_we;
            wmcr_pkg::REG_COLUMN_COUNT: cfg_hit = i_cfg_we;
            wmcr_pkg::REG_ROW_COUNT:    cfg_hit = i_cfg_we;
            default:                    cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n <= 16'd1;
            r_w <= 7'd64;
            r_h <= 9'd64;
        end else if (i_cfg_we) begin
            case (i_cfg.index)
                wmcr_pkg::REG_SAMPLE_COUNT: r_n <= i_cfg.data;
                wmcr_pkg::REG_COLUMN_COUNT: r_w <= i_cfg.data[CW-1:0];
                wmcr_pkg::REG_ROW_COUNT:    r_h <= i_cfg.data[wmcr_pkg::ROWS_W-1:0];
                default:                    r_n <= r_n;
            endcase
        end
    end

    // Restoring divide step: n / w, one quotient bit per cycle
    logic [CW:0] div_trial;
    logic        div_ge;
    assign div_trial = {r_drem, r_quo[NW-1]};
    assign div_ge    = div_trial >= {1'b0, w_eff};

    // Column stepping: next raw end and remainder
    logic [CW:0]   acc_sum;
    logic          acc_carry;
    logic [CW-1:0] acc_next;
    logic [NW-1:0] q_next;
    logic [NW-1:0] cend_next;
    logic [NW-1:0] cend_init;

    assign acc_sum   = {1'b0, r_acc} + {1'b0, r_drem};
    assign acc_carry = acc_sum >= {1'b0, w_eff};
    assign acc_next  = acc_carry ? CW'(acc_sum - {1'b0, w_eff}) : acc_sum[CW-1:0];
    assign q_next    = NW'({1'b0, r_q} + {1'b0, r_quo} + {{NW{1'b0}}, acc_carry});
    // an empty column still covers its first sample
    assign cend_next = (q_next == r_q) ? (r_q + 16'd1) : q_next;
    assign cend_init = (r_quo == '0) ? 16'd1 : r_quo;

    // Row scaling and stretch toward the column just closed
    logic [RW-1:0] top_c, bot_c;
    logic [RW-1:0] st_top, st_bot;
    logic [CW-1:0] col_prev;

    assign top_c    = wmcr_pkg::div255(r_prod_t);
    assign bot_c    = wmcr_pkg::div255(r_prod_b);
    assign col_prev = r_col - 7'd1;

    always_comb begin
        st_top = r_ptop;
        st_bot = r_pbot;
        if (r_pbot < top_c)      st_bot = top_c;
        else if (bot_c < r_ptop) st_top = bot_c;
    end

    // Control-side render state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_samp <= '0;
            r_init <= 1'b0;
            r_min  <= '1;
            r_max  <= '0;
            r_ptop <= '0;
            r_pbot <= '0;
            r_pv   <= 1'b0;
        end else if (cfg_hit) begin
            r_col  <= '0;
            r_samp <= '0;
            r_init <= 1'b0;
            r_min  <= '1;
            r_max  <= '0;
            r_ptop <= '0;
            r_pbot <= '0;
            r_pv   <= 1'b0;
        end else begin
            if (i_cmd.init_cols) r_init <= 1'b1;
            if (i_cmd.finish)    r_samp <= r_samp + 16'd1;
            if (i_cmd.minmax) begin
                if (r_v < r_min) r_min <= r_v;
                if (r_v > r_max) r_max <= r_v;
            end
            if (i_cmd.row) begin
                r_ptop <= top_c;
                r_pbot <= bot_c;
                r_pv   <= 1'b1;
                r_min  <= '1;
                r_max  <= '0;
                if (!o_sts.is_last) r_col <= r_col + 7'd1;
            end
            if (i_cmd.emit_last) begin
                r_pv  <= 1'b0;
                r_col <= w_eff;
            end
        end
    end

    // Datapath payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_v <= i_sample.sample_value;
        if (i_cmd.div_start) begin
            r_quo  <= r_n;
            r_drem <= '0;
        end else if (i_cmd.div_step) begin
            r_quo  <= {r_quo[NW-2:0], div_ge};
            r_drem <= div_ge ? CW'(div_trial - {1'b0, w_eff}) : div_trial[CW-1:0];
        end
        if (i_cmd.init_cols) begin
            r_q    <= r_quo;
            r_acc  <= r_drem;
            r_cend <= cend_init;
        end else if (i_cmd.row) begin
            r_q    <= q_next;
            r_acc  <= acc_next;
            r_cend <= cend_next;
        end
        if (i_cmd.mul) begin
            r_prod_t <= 16'(8'd255 - r_max) * 16'(h_m1);
            r_prod_b <= 16'(8'd255 - r_min) * 16'(h_m1);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if ((i_cmd.row && r_pv) || i_cmd.emit_last) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.row && r_pv) begin
            r_out.column      <= col_prev[wmcr_pkg::COL_W-1:0];
            r_out.top_row     <= st_top;
            r_out.bottom_row  <= st_bot;
            r_out.center_row  <= center;
            r_out.last_column <= 1'b0;
        end else if (i_cmd.emit_last) begin
            r_out.column      <= r_col[wmcr_pkg::COL_W-1:0];
            r_out.top_row     <= r_ptop;
            r_out.bottom_row  <= r_pbot;
            r_out.center_row  <= center;
            r_out.last_column <= 1'b1;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;

    // Status
    assign o_sts.active     = (w_eff != '0) && (r_n != '0) && (r_col < w_eff);
    assign o_sts.init       = r_init;
    assign o_sts.cont       = ({1'b0, r_samp} + 17'd1) < {1'b0, r_cend};
    assign o_sts.brk        = r_q > r_samp;
    assign o_sts.is_last    = ({1'b0, r_col} + 8'd1) >= {1'b0, w_eff};
    assign o_sts.pend_valid = r_pv;
    assign o_sts.out_free   = !r_ovalid || i_out_ready;

endmodule

[hw/rtl/waveform_minmax_column_render_unit.sv]
// ----------------------------------------------------------------------------
// waveform_minmax_column_render_unit
// Min/max waveform preview: samples in, one lit row span per column out.
// ----------------------------------------------------------------------------
// Channels: i_sample takes one 8-bit sample per beat, in order. o_column gives
//   one beat per pixel column (column, top/bottom row, center row, last flag).
//   i_cfg writes sample_count (0), column_count (1) and row_count (2); a write
//   to any of them restarts the render. Write only while the block is idle.
// Sequencing: a sample inside a column is accepted, then folded into min/max.
//   A sample that closes a column adds a multiply and a row step; each
//   further column it closes adds a fold, multiply and row step, plus a
//   final-column step. The first sample after a restart adds the bit-serial
//   n / w divide that seeds column stepping. Samples are taken only in idle.
// Order: a column beat is registered at the row step of the sample that closes
//   the following column (the span is stretched toward its neighbor first);
//   the final column follows after that, once the output register is free.
// Reset: synchronous, active low; registers return to 1 / 64 / 64 and the
//   render restarts. Samples after the final column are dropped.
// Stall: o_column is one output register. While it holds a beat the block
//   keeps accepting samples; it waits only when a new column beat is due.
// ----------------------------------------------------------------------------
module waveform_minmax_column_render_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    wmcr_stream_if.sink   i_sample,
    wmcr_stream_if.sink   i_cfg,
    wmcr_stream_if.source o_column
);

    wmcr_pkg::t_cmd cmd;
    wmcr_pkg::t_sts sts;
    logic           cfg_we;

    // Config writes are always taken
    assign i_cfg.ready = 1'b1;
    assign cfg_we      = i_cfg.valid && i_cfg.ready;

    wmcr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_sample.valid),
        .o_in_ready (i_sample.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    wmcr_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg_we    (cfg_we),
        .i_cfg       (i_cfg.payload),
        .i_sample    (i_sample.payload),
        .o_out_valid (o_column.valid),
        .i_out_ready (o_column.ready),
        .o_out       (o_column.payload)
    );

endmodule

[hw/rtl/wmcr_checker.sv]
// ----------------------------------------------------------------------------
// wmcr_checker
// Port-level checks on the column output channel of the renderer.
// ----------------------------------------------------------------------------
module wmcr_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input wmcr_pkg::t_column i_out
);

    // Stalled beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out)))
        else $error("output beat changed while stalled");

    // Span is never inverted, stretch included
    a_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out.top_row <= i_out.bottom_row))
        else $error("top row below bottom row");

    // Center line is at most half of the largest row count
    a_center: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out.center_row <= 8'd128))
        else $error("center row out of range");

    // Nothing follows right after the final column
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && i_out.last_column) |=> !i_out_valid)
        else $error("beat right after final column");

endmodule

bind waveform_minmax_column_render_unit wmcr_checker u_wmcr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_column.valid),
    .i_out_ready (o_column.ready),
    .i_out       (o_column.payload)
);
